// ===== rtl/ssig_pkg.sv =====
// Shared types and constants for the spiral strip index generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssig_pkg;

   localparam int GRID_W      = 9;
   localparam int INDEX_W     = 16;
   localparam int COUNT_W     = 10;
   localparam int PAIR_W      = 9;
   localparam int PHASE_W     = 2;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   localparam logic [GRID_W-1:0] GRID_RESET = 9'd66;

   typedef enum logic [2:0] {
      KIND_FIRST  = 3'd0,
      KIND_SECOND = 3'd1,
      KIND_PAIR_A = 3'd2,
      KIND_PAIR_B = 3'd3,
      KIND_REPEAT = 3'd4
   } step_kind_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_RIGHT = 2'd0,
      PHASE_DOWN  = 2'd1,
      PHASE_LEFT  = 2'd2,
      PHASE_UP    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [INDEX_W-1:0] vertex_index;
      logic               last;
   } rsp_type;

endpackage

// ===== rtl/spiral_strip_index_generator.sv =====
// Spiral strip index generator: emits one vertex index of an inward-spiraling
// triangle strip over an N by N grid per request transaction; tlast marks the
// final index, after which (or on restart) the strip begins again at 0. It
// takes one request per cycle while the output is not stalled; a taken request
// is held in the input register, and when it fires the walk-state update loads
// its result into the result register. A stalled result holds the input
// register, so requests wait only while the output is full. grid_size is
// written through csr_we/csr_wdata (reset 66); the user must write it only
// while no transaction is in flight, as the block itself does not enforce it.
// Depends on ssig_pkg and the ssig_in_reg, ssig_step and ssig_out_reg modules.
`timescale 1ns / 1ps

module spiral_strip_index_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ssig_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [0] restart
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssig_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // [15:0] vertex_index
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [ssig_pkg::GRID_W-1:0]       csr_wdata    // grid_size
);
   import ssig_pkg::*;

   logic [GRID_W-1:0] grid_size_ff, grid_size_in;
   logic              fire, restart, out_ready;
   rsp_type           result;

   assign grid_size_in = csr_we ? csr_wdata : grid_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_RESET;
      end else begin
         grid_size_ff <= grid_size_in;
      end
   end

   ssig_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_restart (req_tdata[0]),
      .out_ready   (out_ready),
      .fire        (fire),
      .restart     (restart)
   );

   ssig_step u_step (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .restart   (restart),
      .grid_size (grid_size_ff),
      .result    (result)
   );

   ssig_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/ssig_in_reg.sv =====
// Request input register with pass-through ready.
// Depends on ssig_pkg.
`timescale 1ns / 1ps

module ssig_in_reg (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_restart,
   input  logic out_ready,
   output logic fire,
   output logic restart
);
   import ssig_pkg::*;

   logic valid_ff, valid_in;
   logic restart_ff, restart_in;

   assign fire       = valid_ff && out_ready;
   assign req_tready = !valid_ff || out_ready;
   assign restart    = restart_ff;

   always_comb begin
      valid_in   = valid_ff;
      restart_in = restart_ff;
      if (req_tready) begin
         valid_in   = req_tvalid;
         restart_in = req_restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff <= restart_in;
   end

endmodule

// ===== rtl/ssig_step.sv =====
// Spiral walk state and next-index logic, one index per fired transaction.
// Depends on ssig_pkg.
`timescale 1ns / 1ps

module ssig_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic                          restart,
   input  logic [ssig_pkg::GRID_W-1:0]   grid_size,
   output ssig_pkg::rsp_type             result
);
   import ssig_pkg::*;

   step_kind_type               kind_ff, kind_in, kind;
   phase_type                   phase_ff, phase_in;
   logic signed [COUNT_W-1:0]   count_ff, count_in, count_next;
   logic [PAIR_W-1:0]           pair_ff, pair_in;
   logic [INDEX_W-1:0]          h0_ff, h1_ff, h2_ff;
   logic [INDEX_W-1:0]          delta, value;
   logic                        last;
   logic                        count_pos;

   always_comb begin
      unique case (phase_ff)
         PHASE_RIGHT: delta = 16'h0001;
         PHASE_DOWN:  delta = {7'd0, grid_size};
         PHASE_LEFT:  delta = 16'hFFFF;
         PHASE_UP:    delta = 16'h0000 - {7'd0, grid_size};
         default:     delta = 16'h0001;
      endcase
   end

   always_comb begin
      kind       = restart ? KIND_FIRST : kind_ff;
      kind_in    = kind_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      pair_in    = pair_ff;
      count_next = count_ff;
      count_pos  = 1'b0;
      value      = '0;
      last       = 1'b0;
      unique case (kind)
         KIND_SECOND: begin
            value      = {7'd0, grid_size};
            count_next = $signed({1'b0, grid_size} - 10'd1);
            count_in   = count_next;
            phase_in   = PHASE_RIGHT;
            count_pos  = !count_next[COUNT_W-1] && (count_next != '0);
            pair_in    = '0;
            if (count_pos) begin
               kind_in = KIND_PAIR_A;
            end else begin
               last    = 1'b1;
               kind_in = KIND_FIRST;
            end
         end
         KIND_PAIR_A: begin
            value   = h1_ff + delta;
            kind_in = KIND_PAIR_B;
         end
         KIND_PAIR_B: begin
            value   = h1_ff + delta;
            pair_in = pair_ff + 9'd1;
            if ($signed({2'b00, pair_in}) < $signed({count_ff[COUNT_W-1], count_ff})) begin
               kind_in = KIND_PAIR_A;
            end else begin
               kind_in = KIND_REPEAT;
            end
         end
         KIND_REPEAT: begin
            value = h2_ff;
            if (phase_ff == PHASE_RIGHT || phase_ff == PHASE_LEFT) begin
               count_next = count_ff - 10'sd1;
            end
            count_in  = count_next;
            count_pos = !count_next[COUNT_W-1] && (count_next != '0);
            pair_in   = '0;
            if (phase_ff == PHASE_UP) begin
               phase_in = PHASE_RIGHT;
               if (count_pos) begin
                  kind_in = KIND_PAIR_A;
               end else begin
                  last    = 1'b1;
                  kind_in = KIND_FIRST;
               end
            end else begin
               phase_in = phase_type'(phase_ff + 2'd1);
               kind_in  = count_pos ? KIND_PAIR_A : KIND_REPEAT;
            end
         end
         default: begin
            value   = '0;
            kind_in = KIND_SECOND;
         end
      endcase
   end

   assign result.vertex_index = value;
   assign result.last         = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= KIND_FIRST;
         phase_ff <= PHASE_RIGHT;
         count_ff <= $signed({1'b0, GRID_RESET} - 10'd1);
         pair_ff  <= '0;
         h0_ff    <= '0;
         h1_ff    <= '0;
         h2_ff    <= '0;
      end else if (fire) begin
         kind_ff  <= kind_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         pair_ff  <= pair_in;
         h0_ff    <= value;
         h1_ff    <= h0_ff;
         h2_ff    <= h1_ff;
      end
   end

endmodule

// ===== rtl/ssig_out_reg.sv =====
// Response output register; holds a result until the sink takes it.
// Depends on ssig_pkg.
`timescale 1ns / 1ps

module ssig_out_reg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              fire,
   input  ssig_pkg::rsp_type                 result,
   output logic                              out_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssig_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast
);
   import ssig_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign out_ready  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.vertex_index;
   assign rsp_tlast  = data_ff.last;

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

endmodule

// ===== rtl/ssig_checker.sv =====
// Port-level checks for the spiral strip index generator, bound to the top.
// Depends on ssig_pkg and spiral_strip_index_generator.
`timescale 1ns / 1ps

module ssig_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ssig_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tlast
);
   import ssig_pkg::*;

   logic       req_take, rsp_take;
   logic [1:0] pending_ff, pending_in;
   logic       expect_zero_ff, expect_zero_in;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         pending_in = pending_ff - 2'd1;
      end
      expect_zero_in = expect_zero_ff;
      if (rsp_take) begin
         expect_zero_in = rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= '0;
         expect_zero_ff <= 1'b1;
      end else begin
         pending_ff     <= pending_in;
         expect_zero_ff <= expect_zero_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0 && pending_ff != 2'd3)
      else $error("response without matching request");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled while output empty");

   a_strip_starts_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_take && expect_zero_ff |-> rsp_tdata == '0)
      else $error("strip did not start at index 0");

endmodule

bind spiral_strip_index_generator ssig_checker u_ssig_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
